[rtl/grid_path_counter_with_obstacles_macros.svh]
// Assertion macros used by the grid path counter back end.
`ifndef GRID_PATH_COUNTER_WITH_OBSTACLES_MACROS_SVH
`define GRID_PATH_COUNTER_WITH_OBSTACLES_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define GPC_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define GPC_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

[rtl/gpc_pkg.sv]
// Shared types and constants of the grid path counter.
package gpc_pkg;

   localparam int COUNT_W     = 30;
   localparam int ROWS_W      = 16;
   localparam int COLS_CFG_W  = 11;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam logic [COUNT_W-1:0] PATH_MOD = 30'd1000000007;

   // Configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_GRID_ROWS = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_GRID_COLS = 2'd1;

   // Position class of one cell, handed from the front end to the back end
   typedef struct packed {
      logic blocked;
      logic first_row;
      logic first_col;
      logic last_col;
      logic last_cell;
   } cell_flags_type;

endpackage

[rtl/grid_path_counter_with_obstacles.sv]
// Top level of the grid path counter: front end, cell queue and back end.
//
// Counts right/down paths from the top-left to the bottom-right cell of a grid of
// grid_rows by grid_cols cells, modulo 1000000007. Send one transaction per cell in
// row-major order with req_blocked set for an obstacle; after the last cell of the
// grid one rsp transaction carries the corner count (0 when the origin or the
// corner is blocked), and the next cell starts a new grid. A grid_rows or grid_cols
// of 0 acts as 1, and grid_cols saturates at MAX_COLS. Any write to grid_rows or
// grid_cols restarts the sweep; write them only while no cell is in flight. The
// block takes one cell per cycle while the queue has room: the front end tags each
// cell with its position (first row, first column, last column, last cell) and
// pushes it into a two-entry queue; the back end reads the count of the cell above
// from a MAX_COLS-deep row buffer, then adds the left count, reduces and writes
// back, forwarding the value just written when the same column is read again (a
// one-column grid). The result passes through the queue, the back end's read stage
// and stage B; it is held back only while the previous result has not been taken
// yet, and waits in an output register, so cells of the next grid keep flowing
// while it waits. The row buffer needs no clearing after reset: the first row of
// every grid writes each column before any later row reads it.
module grid_path_counter_with_obstacles #(
   parameter int MAX_COLS = 1024
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [gpc_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [gpc_pkg::CSR_DATA_W-1:0]   csr_wr_data,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_blocked,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [gpc_pkg::COUNT_W-1:0]      rsp_path_count
);

   import gpc_pkg::*;

   localparam int COL_W   = $clog2(MAX_COLS);
   localparam int FLAGS_W = $bits(cell_flags_type);
   localparam int CMD_W   = FLAGS_W + COL_W;

   // Front end to queue
   logic             fe_valid, fe_ready;
   cell_flags_type   fe_flags;
   logic [COL_W-1:0] fe_col;

   // Queue to back end
   logic             be_valid, be_ready;
   logic [CMD_W-1:0] be_cmd;
   cell_flags_type   be_flags;
   logic [COL_W-1:0] be_col;

   gpc_front #(
      .MAX_COLS (MAX_COLS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_blocked (req_blocked),
      .cmd_valid   (fe_valid),
      .cmd_ready   (fe_ready),
      .cmd_flags   (fe_flags),
      .cmd_col     (fe_col)
   );

   // Hold up to two tagged cells so each side can stall on its own
   gpc_queue #(
      .WIDTH (CMD_W),
      .DEPTH (2)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (fe_valid),
      .wr_ready (fe_ready),
      .wr_data  ({fe_flags, fe_col}),
      .rd_valid (be_valid),
      .rd_ready (be_ready),
      .rd_data  (be_cmd)
   );

   assign be_flags = cell_flags_type'(be_cmd[CMD_W-1:COL_W]);
   assign be_col   = be_cmd[COL_W-1:0];

   gpc_back #(
      .MAX_COLS (MAX_COLS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .cmd_valid      (be_valid),
      .cmd_ready      (be_ready),
      .cmd_flags      (be_flags),
      .cmd_col        (be_col),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_path_count (rsp_path_count)
   );

endmodule

[rtl/gpc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module gpc_ram #(
   parameter int WIDTH = 30,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/gpc_queue.sv]
// Short first-in first-out queue between the front end and the back end.
module gpc_queue #(
   parameter int WIDTH = 15,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_valid,
   output logic             wr_ready,
   input  logic [WIDTH-1:0] wr_data,
   output logic             rd_valid,
   input  logic             rd_ready,
   output logic [WIDTH-1:0] rd_data
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push, pop;

   assign wr_ready = (count_ff != CNT_W'(DEPTH));
   assign rd_valid = (count_ff != '0);
   assign rd_data  = mem_ff[rd_ptr_ff];
   assign push     = wr_valid && wr_ready;
   assign pop      = rd_valid && rd_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

[rtl/gpc_front.sv]
// Front end: takes cell transactions, tracks the grid position and tags each cell.
module gpc_front #(
   parameter int MAX_COLS = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [gpc_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [gpc_pkg::CSR_DATA_W-1:0]      csr_wr_data,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_blocked,
   output logic                                cmd_valid,
   input  logic                                cmd_ready,
   output gpc_pkg::cell_flags_type             cmd_flags,
   output logic [$clog2(MAX_COLS)-1:0]         cmd_col
);

   import gpc_pkg::*;

   localparam int COL_W = $clog2(MAX_COLS);
   localparam int CMP_W = (COL_W + 1 > COLS_CFG_W) ? COL_W + 1 : COLS_CFG_W;

   logic [ROWS_W-1:0]     grid_rows_ff, grid_rows_in;
   logic [COLS_CFG_W-1:0] grid_cols_ff, grid_cols_in;
   logic [ROWS_W-1:0]     row_ff, row_in;
   logic [COL_W-1:0]      col_ff, col_in;
   logic [CMP_W-1:0]      cols_ext, cols_lim;
   logic [COL_W-1:0]      col_last;
   logic [ROWS_W-1:0]     row_last;
   logic                  at_last_col, at_last_row, accept;

   // Clamp the column count to 1..MAX_COLS and the row count to at least 1
   always_comb begin
      cols_ext = CMP_W'(grid_cols_ff);
      if (cols_ext == '0) begin
         cols_lim = CMP_W'(1);
      end else if (cols_ext > CMP_W'(MAX_COLS)) begin
         cols_lim = CMP_W'(MAX_COLS);
      end else begin
         cols_lim = cols_ext;
      end
      col_last = COL_W'(cols_lim - CMP_W'(1));
      row_last = (grid_rows_ff == '0) ? '0 : grid_rows_ff - 1'b1;
   end

   assign at_last_col = (col_ff == col_last);
   assign at_last_row = (row_ff == row_last);
   assign req_ready   = cmd_ready;
   assign cmd_valid   = req_valid;
   assign accept      = req_valid && cmd_ready;

   assign cmd_col             = col_ff;
   assign cmd_flags.blocked   = req_blocked;
   assign cmd_flags.first_row = (row_ff == '0);
   assign cmd_flags.first_col = (col_ff == '0);
   assign cmd_flags.last_col  = at_last_col;
   assign cmd_flags.last_cell = at_last_col && at_last_row;

   always_comb begin
      grid_rows_in = grid_rows_ff;
      grid_cols_in = grid_cols_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            REG_GRID_ROWS: begin
               grid_rows_in = csr_wr_data;
               row_in       = '0;
               col_in       = '0;
            end
            REG_GRID_COLS: begin
               grid_cols_in = csr_wr_data[COLS_CFG_W-1:0];
               row_in       = '0;
               col_in       = '0;
            end
            default: begin
            end
         endcase
      end else if (accept) begin
         if (at_last_col) begin
            col_in = '0;
            row_in = at_last_row ? '0 : row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_rows_ff <= ROWS_W'(3);
         grid_cols_ff <= COLS_CFG_W'(3);
         row_ff       <= '0;
         col_ff       <= '0;
      end else begin
         grid_rows_ff <= grid_rows_in;
         grid_cols_ff <= grid_cols_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
      end
   end

endmodule

[rtl/gpc_back.sv]
// Back end: reads the row buffer, adds above and left counts modulo the prime, writes back.
`include "grid_path_counter_with_obstacles_macros.svh"

module gpc_back #(
   parameter int MAX_COLS = 1024
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            cmd_valid,
   output logic                            cmd_ready,
   input  gpc_pkg::cell_flags_type         cmd_flags,
   input  logic [$clog2(MAX_COLS)-1:0]     cmd_col,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [gpc_pkg::COUNT_W-1:0]     rsp_path_count
);

   import gpc_pkg::*;

   localparam int COL_W = $clog2(MAX_COLS);

   logic                 b_valid_ff, b_valid_in;
   cell_flags_type       b_flags_ff;
   logic [COL_W-1:0]     b_col_ff;
   logic                 fwd_ff, fwd_in;
   logic [COUNT_W-1:0]   fwd_val_ff;
   logic [COUNT_W-1:0]   left_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0]   rsp_path_count_ff;
   logic [COUNT_W-1:0]   rd_data, above, left, cell_val;
   logic [COUNT_W:0]     sum;
   logic                 a_fire, b_fire;

   // Stage B may retire unless it carries the final cell and the result slot is full and not being taken
   assign b_fire    = b_valid_ff &&
                      (!b_flags_ff.last_cell || !rsp_valid_ff || rsp_ready);
   assign a_fire    = cmd_valid && (!b_valid_ff || b_fire);
   assign cmd_ready = a_fire;

   // A read issued in the cycle the same column is written returns old data: forward
   assign fwd_in     = b_fire && (b_col_ff == cmd_col);
   assign b_valid_in = a_fire ? 1'b1 : (b_fire ? 1'b0 : b_valid_ff);

   always_comb begin
      above = b_flags_ff.first_row ? '0 : (fwd_ff ? fwd_val_ff : rd_data);
      left  = b_flags_ff.first_col ? '0 : left_ff;
      sum   = {1'b0, above} + {1'b0, left};
      if (sum >= {1'b0, PATH_MOD}) begin
         sum = sum - {1'b0, PATH_MOD};
      end
      if (b_flags_ff.blocked) begin
         cell_val = '0;
      end else if (b_flags_ff.first_row && b_flags_ff.first_col) begin
         cell_val = COUNT_W'(1);
      end else begin
         cell_val = sum[COUNT_W-1:0];
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (b_fire && b_flags_ff.last_cell) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   gpc_ram #(
      .WIDTH (COUNT_W),
      .DEPTH (MAX_COLS)
   ) u_row_buf (
      .clock   (clock),
      .wr_en   (b_fire),
      .wr_addr (b_col_ff),
      .wr_data (cell_val),
      .rd_en   (a_fire),
      .rd_addr (cmd_col),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         fwd_ff       <= 1'b0;
      end else begin
         b_valid_ff   <= b_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (a_fire) begin
            fwd_ff <= fwd_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (a_fire) begin
         b_flags_ff <= cmd_flags;
         b_col_ff   <= cmd_col;
         fwd_val_ff <= cell_val;
      end
      if (b_fire) begin
         left_ff <= cell_val;
         if (b_flags_ff.last_cell) begin
            rsp_path_count_ff <= cell_val;
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_path_count = rsp_path_count_ff;

   `GPC_ASSERT(a_count_in_range, rsp_valid_ff |-> (rsp_path_count_ff < PATH_MOD), "path count not reduced")
   `GPC_ASSERT(a_final_lands, (b_fire && b_flags_ff.last_cell) |=> rsp_valid_ff, "final count lost")
   `GPC_ASSERT(a_stall_holds, (b_valid_ff && !b_fire) |=> ($stable(b_col_ff) && b_valid_ff), "stalled cell moved")
   `GPC_ASSERT_ALWAYS(a_reset_idle, reset |=> (!b_valid_ff && !rsp_valid_ff), "pipeline busy after reset")

endmodule
